@@ rtl/cts_pkg.sv @@
// Shared types and constants for the throttle slew limiter.
`default_nettype none
package cts_pkg;
	localparam int ID_W   = 29;
	localparam int LVL_W  = 8;
	localparam int REG_W  = 16;
	localparam int CFG_W  = 29;
	localparam int IDX_W  = 2;
	localparam int IN_W   = 40;
	localparam int OUT_W  = 16;

	typedef enum logic [IDX_W-1:0] {
		REG_THROTTLE_ID = 2'd0,
		REG_RAMP_MS     = 2'd1,
		REG_STALE_MS    = 2'd2,
		REG_BEAT_MS     = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_FRAME = 1'b1
	} op_t;

	typedef struct packed {
		logic [ID_W-1:0]  throttle_id;
		logic [REG_W-1:0] ramp_ms;
		logic [REG_W-1:0] stale_ms;
		logic [REG_W-1:0] beat_ms;
	} cts_cfg_t;

	typedef struct packed {
		logic             heartbeat_send;
		logic             stale_cut;
		logic [LVL_W-1:0] throttle_out;
	} cts_result_t;
endpackage
`default_nettype wire

@@ rtl/cts_update.sv @@
// Per-item state update: age advance, slew limit, stale cut and heartbeat check.
`default_nettype none
module cts_update #(
	parameter int AGE_BITS = 16
) (
	input  cts_pkg::cts_cfg_t            cfg,
	input  cts_pkg::op_t                 op,
	input  logic [cts_pkg::ID_W-1:0]     frame_id,
	input  logic [cts_pkg::LVL_W-1:0]    data_byte,
	input  logic [cts_pkg::LVL_W-1:0]    level,
	input  logic [cts_pkg::LVL_W-1:0]    target,
	input  logic [AGE_BITS-1:0]          msg_age,
	input  logic [AGE_BITS-1:0]          ramp_age,
	input  logic [AGE_BITS-1:0]          beat_age,
	output logic [cts_pkg::LVL_W-1:0]    level_nx,
	output logic [cts_pkg::LVL_W-1:0]    target_nx,
	output logic [AGE_BITS-1:0]          msg_age_nx,
	output logic [AGE_BITS-1:0]          ramp_age_nx,
	output logic [AGE_BITS-1:0]          beat_age_nx,
	output cts_pkg::cts_result_t         result
);
	import cts_pkg::*;

	localparam int CMP_W = (AGE_BITS > REG_W) ? AGE_BITS : REG_W;

	logic [AGE_BITS-1:0] msg_a, ramp_a, beat_a;
	logic [LVL_W-1:0]    tgt, lvl;
	logic                cut, beat;

	always_comb begin
		msg_a  = msg_age;
		ramp_a = ramp_age;
		beat_a = beat_age;
		tgt    = target;
		lvl    = level;
		cut    = 1'b0;
		beat   = 1'b0;

		if (op == OP_TICK) begin
			msg_a  = (&msg_age)  ? msg_age  : msg_age  + 1'b1;
			ramp_a = (&ramp_age) ? ramp_age : ramp_age + 1'b1;
			beat_a = (&beat_age) ? beat_age : beat_age + 1'b1;
		end else if (frame_id == cfg.throttle_id) begin
			tgt   = data_byte;
			msg_a = '0;
		end

		if (tgt > lvl) begin
			if (CMP_W'(ramp_a) > CMP_W'(cfg.ramp_ms)) begin
				lvl    = lvl + 1'b1;
				ramp_a = '0;
			end
		end else if (tgt < lvl) begin
			lvl = tgt;
		end

		if (lvl != '0 && CMP_W'(msg_a) > CMP_W'(cfg.stale_ms)) begin
			lvl = '0;
			cut = 1'b1;
		end

		if (CMP_W'(beat_a) > CMP_W'(cfg.beat_ms)) begin
			beat_a = '0;
			beat   = 1'b1;
		end

		level_nx              = lvl;
		target_nx             = tgt;
		msg_age_nx            = msg_a;
		ramp_age_nx           = ramp_a;
		beat_age_nx           = beat_a;
		result.throttle_out   = lvl;
		result.stale_cut      = cut;
		result.heartbeat_send = beat;
	end
endmodule
`default_nettype wire

@@ rtl/can_throttle_slew_limiter.sv @@
// Top level of the throttle slew limiter with command timeout and heartbeat pacing.
// A transaction passes through the input register and then the result register before it shows on m_tdata.
// Throughput: one transaction per cycle; the input register and the update logic
// advance together whenever the result register is empty or being drained.
// Reset (arst_n low) clears configuration, level, target, ages and all valid flags.
`default_nettype none
module can_throttle_slew_limiter #(
	parameter int AGE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cts_pkg::IDX_W-1:0]     cfg_index,
	input  logic [cts_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cts_pkg::IN_W-1:0]      s_tdata,   // frame_id[28:0], data_byte[36:29], zeros
	input  logic                          s_tuser,   // operation
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cts_pkg::OUT_W-1:0]     m_tdata    // throttle_out[7:0], stale_cut, heartbeat_send, zeros
);
	import cts_pkg::*;

	cts_cfg_t            cfg_q;
	logic                valid_s1;
	op_t                 op_s1;
	logic [ID_W-1:0]     fid_s1;
	logic [LVL_W-1:0]    byte_s1;
	logic [LVL_W-1:0]    level_q, target_q;
	logic [AGE_BITS-1:0] msg_age_q, ramp_age_q, beat_age_q;
	logic                out_valid_q;
	cts_result_t         result_q;

	logic [LVL_W-1:0]    level_nx, target_nx;
	logic [AGE_BITS-1:0] msg_age_nx, ramp_age_nx, beat_age_nx;
	cts_result_t         result_nx;
	logic                advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(result_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THROTTLE_ID: cfg_q.throttle_id <= cfg_data;
				REG_RAMP_MS:     cfg_q.ramp_ms     <= cfg_data[REG_W-1:0];
				REG_STALE_MS:    cfg_q.stale_ms    <= cfg_data[REG_W-1:0];
				REG_BEAT_MS:     cfg_q.beat_ms     <= cfg_data[REG_W-1:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= op_t'(s_tuser);
			fid_s1  <= s_tdata[ID_W-1:0];
			byte_s1 <= s_tdata[ID_W+LVL_W-1:ID_W];
		end
	end

	cts_update #(
		.AGE_BITS(AGE_BITS)
	) u_update (
		.cfg         (cfg_q),
		.op          (op_s1),
		.frame_id    (fid_s1),
		.data_byte   (byte_s1),
		.level       (level_q),
		.target      (target_q),
		.msg_age     (msg_age_q),
		.ramp_age    (ramp_age_q),
		.beat_age    (beat_age_q),
		.level_nx    (level_nx),
		.target_nx   (target_nx),
		.msg_age_nx  (msg_age_nx),
		.ramp_age_nx (ramp_age_nx),
		.beat_age_nx (beat_age_nx),
		.result      (result_nx)
	);

	// Commit state and result together when the item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= '0;
			target_q   <= '0;
			msg_age_q  <= '0;
			ramp_age_q <= '0;
			beat_age_q <= '0;
		end else if (advance) begin
			level_q    <= level_nx;
			target_q   <= target_nx;
			msg_age_q  <= msg_age_nx;
			ramp_age_q <= ramp_age_nx;
			beat_age_q <= beat_age_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nx;
		end
	end
endmodule
`default_nettype wire

@@ bench/tb_can_throttle_slew_limiter.sv @@
// Self-checking testbench for the throttle slew limiter with a scoreboard that checks every transaction.
`default_nettype none

class throttle_scoreboard #(int AGE_W = 16);
	logic [cts_pkg::ID_W-1:0]  cmd_id;
	logic [cts_pkg::REG_W-1:0] ramp_ms;
	logic [cts_pkg::REG_W-1:0] stale_ms;
	logic [cts_pkg::REG_W-1:0] beat_ms;
	logic [cts_pkg::LVL_W-1:0] level;
	logic [cts_pkg::LVL_W-1:0] target;
	logic [AGE_W-1:0]          msg_age;
	logic [AGE_W-1:0]          ramp_age;
	logic [AGE_W-1:0]          beat_age;
	cts_pkg::cts_result_t      pending_levels[$];
	int                        errors;

	function new();
		cmd_id   = '0;
		ramp_ms  = '0;
		stale_ms = '0;
		beat_ms  = '0;
		level    = '0;
		target   = '0;
		msg_age  = '0;
		ramp_age = '0;
		beat_age = '0;
		errors   = 0;
	endfunction

	function void set_reg(cts_pkg::cfg_reg_t idx, logic [cts_pkg::CFG_W-1:0] val);
		case (idx)
			cts_pkg::REG_THROTTLE_ID: cmd_id   = val[cts_pkg::ID_W-1:0];
			cts_pkg::REG_RAMP_MS:     ramp_ms  = val[cts_pkg::REG_W-1:0];
			cts_pkg::REG_STALE_MS:    stale_ms = val[cts_pkg::REG_W-1:0];
			cts_pkg::REG_BEAT_MS:     beat_ms  = val[cts_pkg::REG_W-1:0];
			default: ;
		endcase
	endfunction

	function logic [AGE_W-1:0] age_up(logic [AGE_W-1:0] a);
		return (a == {AGE_W{1'b1}}) ? a : a + 1'b1;
	endfunction

	function void take_command(cts_pkg::op_t op, logic [cts_pkg::ID_W-1:0] fid,
			logic [cts_pkg::LVL_W-1:0] lvl);
		cts_pkg::cts_result_t res;
		res = '0;
		if (op == cts_pkg::OP_TICK) begin
			msg_age  = age_up(msg_age);
			ramp_age = age_up(ramp_age);
			beat_age = age_up(beat_age);
		end else if (fid == cmd_id) begin
			target  = lvl;
			msg_age = '0;
		end
		if (target > level) begin
			if (ramp_age > ramp_ms) begin
				level    = level + 1'b1;
				ramp_age = '0;
			end
		end else if (target < level) begin
			level = target;
		end
		if (level != '0 && msg_age > stale_ms) begin
			level         = '0;
			res.stale_cut = 1'b1;
		end
		if (beat_age > beat_ms) begin
			beat_age           = '0;
			res.heartbeat_send = 1'b1;
		end
		res.throttle_out = level;
		pending_levels.push_back(res);
	endfunction

	function void report(string field, logic [7:0] exp_v, logic [7:0] got_v);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
	endfunction

	function void check_level(cts_pkg::cts_result_t got);
		cts_pkg::cts_result_t exp_r;
		if (pending_levels.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual %0d/%0b/%0b", $time,
				got.throttle_out, got.stale_cut, got.heartbeat_send);
			return;
		end
		exp_r = pending_levels.pop_front();
		if (got.throttle_out !== exp_r.throttle_out)
			report("throttle_out", exp_r.throttle_out, got.throttle_out);
		if (got.stale_cut !== exp_r.stale_cut)
			report("stale_cut", 8'(exp_r.stale_cut), 8'(got.stale_cut));
		if (got.heartbeat_send !== exp_r.heartbeat_send)
			report("heartbeat_send", 8'(exp_r.heartbeat_send), 8'(got.heartbeat_send));
	endfunction
endclass

module tb_can_throttle_slew_limiter;
	import cts_pkg::*;

	localparam int AGE_BITS   = 16;
	localparam int CYCLE_CAP  = 1000000;
	localparam int SEG_ITEMS  = 85;
	localparam int SEG_COUNT  = 13;
	localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;   // frame_id[28:0], data_byte[36:29], zeros
	logic              s_tuser;   // operation
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;   // throttle_out[7:0], stale_cut, heartbeat_send, zeros

	int send_idle = 0;
	int recv_idle = 0;
	int cycles    = 0;

	throttle_scoreboard #(AGE_BITS) sb;

	can_throttle_slew_limiter #(.AGE_BITS(AGE_BITS)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb_can_throttle_slew_limiter: errors");
			$finish;
		end else if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_level(cts_result_t'(m_tdata[$bits(cts_result_t)-1:0]));
			if (s_tvalid && s_tready)
				sb.take_command(op_t'(s_tuser), s_tdata[ID_W-1:0],
					s_tdata[ID_W+LVL_W-1:ID_W]);
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] id, input logic [CFG_W-1:0] ramp,
			input logic [CFG_W-1:0] stale, input logic [CFG_W-1:0] beat);
		write_reg(REG_THROTTLE_ID, id);
		write_reg(REG_RAMP_MS, ramp);
		write_reg(REG_STALE_MS, stale);
		write_reg(REG_BEAT_MS, beat);
		cfg_we = 1'b0;
	endtask

	task automatic send_item(input op_t op, input logic [ID_W-1:0] fid,
			input logic [LVL_W-1:0] lvl);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {3'b000, lvl, fid};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic tick();
		send_item(OP_TICK, ID_W'($urandom), 8'($urandom));
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (sb.pending_levels.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_ms(input int hi);
		logic [CFG_W-1:0] v;
		v = CFG_W'($urandom) & ~CFG_W'(16'hFFFF);
		case ($urandom_range(9))
			0:       v[REG_W-1:0] = '0;
			1:       v[REG_W-1:0] = 16'hFFFF;
			2:       v[REG_W-1:0] = 16'hFFFE;
			default: v[REG_W-1:0] = REG_W'($urandom_range(hi));
		endcase
		return v;
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		case ($urandom_range(5))
			0:       return '0;
			1:       return ID_MAX;
			default: return ID_W'($urandom);
		endcase
	endfunction

	function automatic logic [LVL_W-1:0] pick_level();
		case ($urandom_range(7))
			0:       return '0;
			1:       return 8'hFF;
			2:       return sb.level + 8'($urandom_range(3));
			default: return 8'($urandom_range(40));
		endcase
	endfunction

	task automatic run_random(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 55)
				tick();
			else if (r < 85)
				send_item(OP_FRAME, sb.cmd_id, (r < 60) ? 8'($urandom) : pick_level());
			else
				send_item(OP_FRAME, ID_W'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		sb        = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_THROTTLE_ID;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tuser   = OP_TICK;
		s_tdata   = '0;
		send_idle = 26;
		recv_idle = 86;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_config(29'h1555_5555, 29'h0, 29'h3, 29'h2);
		tick();
		send_item(OP_FRAME, 29'h1555_5555, 8'hFF);
		repeat (4) tick();
		send_item(OP_FRAME, 29'h1555_5555, 8'h00);
		send_item(OP_FRAME, 29'h1555_5555, 8'h0A);
		repeat (3) tick();
		send_item(OP_FRAME, 29'h1555_5555, 8'h01);
		send_item(OP_FRAME, 29'h1555_5554, 8'hC8);
		send_item(OP_FRAME, ID_MAX, 8'hAA);
		send_item(OP_FRAME, 29'h0, 8'h55);
		drain();
		set_config({13'h1FFF, ID_MAX}, 29'h3, 29'h1FFF_FFFF, 29'h0);
		send_item(OP_FRAME, ID_MAX, 8'hFF);
		repeat (6) tick();
		send_item(OP_FRAME, ID_MAX, 8'h00);
		drain();
		set_config(29'h0, 29'hFFFF, 29'h0, 29'hFFFF);
		send_item(OP_FRAME, 29'h0, 8'h07);
		tick();
		drain();

		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			if (seg == 5) begin
				send_idle = 86;
				recv_idle = 26;
			end else if (seg == 9) begin
				send_idle = 0;
				recv_idle = 0;
				set_config(29'h0ABC_DEF, 29'h0, 29'h00C8, 29'h00C8);
				send_item(OP_FRAME, 29'h0ABC_DEF, 8'hFF);
				repeat (203) tick();
				send_item(OP_FRAME, 29'h0ABC_DEE, 8'h33);
				repeat (3) tick();
				drain();
			end
			set_config(pick_id(), pick_ms(6), pick_ms(40), pick_ms(12));
			run_random(SEG_ITEMS);
			drain();
		end

		drain();
		repeat (8) @(negedge clk);
		if (sb.pending_levels.size() != 0)
			sb.errors++;
		if (sb.errors == 0)
			$display("tb_can_throttle_slew_limiter: clean");
		else
			$display("tb_can_throttle_slew_limiter: errors");
		$finish;
	end
endmodule

`default_nettype wire

@@ filelist.f @@
rtl/cts_pkg.sv
rtl/cts_update.sv
rtl/can_throttle_slew_limiter.sv
bench/tb_can_throttle_slew_limiter.sv
